// File: sv/rdr_pkg.sv
// Package for the relative direction rotation block.
// Holds CORDIC constants, arctangent table and fixed-point helpers; no dependencies.
package rdr_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FIELD_W           = 16;
  localparam int PH_W              = 32;
  // CORDIC datapath width; Q2.30 plus guard bits
  localparam int DW                = 36;
  localparam int QW                = 18;   // Q2.16 vector component width
  localparam int ACC_W             = 34;   // phase accumulator, signed

  localparam logic signed [DW-1:0] GAIN_Q30 = DW'(652032874);
  localparam logic signed [QW-1:0] Q16_MAX  = QW'(131071);
  localparam logic signed [QW-1:0] Q16_MIN  = -QW'(131072);
  localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'd2147483648);

  typedef logic signed [DW-1:0]    dat_t;
  typedef logic signed [QW-1:0]    q16_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [FIELD_W-1:0] base_zenith;
    logic [FIELD_W-1:0] base_azimuth;
    logic [FIELD_W-1:0] rel_zenith;
    logic [FIELD_W-1:0] rel_azimuth;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_zenith;
    logic [FIELD_W-1:0] out_azimuth;
  } out_word_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [PH_W-1:0] atan_lut(input logic [4:0] i);
    logic [PH_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic q16_t sat16(input logic signed [47:0] v);
    if (v > 48'(Q16_MAX)) return Q16_MAX;
    if (v < 48'(Q16_MIN)) return Q16_MIN;
    return QW'(v);
  endfunction

  // rounded, saturated a*b + c*d with Q2.16 operands
  function automatic q16_t mac2(input q16_t a, input q16_t b, input q16_t c, input q16_t d);
    logic signed [47:0] s;
    s = 48'(a) * 48'(b) + 48'(c) * 48'(d) + 48'sd32768;
    return sat16(s >>> 16);
  endfunction

endpackage

// File: sv/rdr_if.sv
// Valid/ready channel interface for the rotation block.
// Parameterized by payload type; no package dependency.
interface rdr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/rdr_rot_cell.sv
// One CORDIC rotation-mode cell: one micro-rotation, registered.
// Depends on rdr_pkg.
module rdr_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  rdr_pkg::dat_t  x_i,
  input  rdr_pkg::dat_t  y_i,
  input  rdr_pkg::acc_t  res_i,
  output rdr_pkg::dat_t  x_o,
  output rdr_pkg::dat_t  y_o,
  output rdr_pkg::acc_t  res_o
);
  rdr_pkg::dat_t x_r, y_r;
  rdr_pkg::acc_t res_r;
  rdr_pkg::acc_t ang;

  assign ang = rdr_pkg::ACC_W'(rdr_pkg::atan_lut(5'(STAGE)));

  // rotate toward residual zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (!res_i[rdr_pkg::ACC_W-1]) begin
        x_r   <= x_i - (y_i >>> STAGE);
        y_r   <= y_i + (x_i >>> STAGE);
        res_r <= res_i - ang;
      end else begin
        x_r   <= x_i + (y_i >>> STAGE);
        y_r   <= y_i - (x_i >>> STAGE);
        res_r <= res_i + ang;
      end
    end
  end
  assign x_o = x_r;
  assign y_o = y_r;
  assign res_o = res_r;
endmodule

// File: sv/rdr_vec_cell.sv
// One CORDIC vectoring-mode cell: drives y toward zero, registered.
// Depends on rdr_pkg.
module rdr_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  rdr_pkg::dat_t  x_i,
  input  rdr_pkg::dat_t  y_i,
  input  rdr_pkg::acc_t  acc_i,
  output rdr_pkg::dat_t  x_o,
  output rdr_pkg::dat_t  y_o,
  output rdr_pkg::acc_t  acc_o
);
  rdr_pkg::dat_t x_r, y_r;
  rdr_pkg::acc_t acc_r;
  rdr_pkg::acc_t ang;

  assign ang = rdr_pkg::ACC_W'(rdr_pkg::atan_lut(5'(STAGE)));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[rdr_pkg::DW-1]) begin
        x_r   <= x_i + (y_i >>> STAGE);
        y_r   <= y_i - (x_i >>> STAGE);
        acc_r <= acc_i + ang;
      end else begin
        x_r   <= x_i - (y_i >>> STAGE);
        y_r   <= y_i + (x_i >>> STAGE);
        acc_r <= acc_i - ang;
      end
    end
  end
  assign x_o = x_r;
  assign y_o = y_r;
  assign acc_o = acc_r;
endmodule

// File: sv/rdr_sincos.sv
// Sine/cosine unit: quadrant fold plus a chain of rotation cells.
// Depends on rdr_pkg and rdr_rot_cell.
module rdr_sincos #(
  parameter int ANGLE_BITS    = rdr_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rdr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rdr_pkg::FIELD_W-1:0]   ang_i,
  output rdr_pkg::q16_t                 cos_o,
  output rdr_pkg::q16_t                 sin_o
);
  localparam int SH = rdr_pkg::PH_W - ANGLE_BITS;
  localparam int AW = (ANGLE_BITS < rdr_pkg::FIELD_W) ? ANGLE_BITS : rdr_pkg::FIELD_W;

  logic [rdr_pkg::PH_W-1:0] ph;
  rdr_pkg::dat_t xs [CORDIC_STAGES+1];
  rdr_pkg::dat_t ys [CORDIC_STAGES+1];
  rdr_pkg::acc_t rs [CORDIC_STAGES+1];
  logic [1:0]    qd [CORDIC_STAGES+1];
  rdr_pkg::dat_t xr, yr;
  rdr_pkg::q16_t c, s;

  // input angle to 32-bit phase
  assign ph = rdr_pkg::PH_W'({{(rdr_pkg::PH_W-AW){1'b0}}, ang_i[AW-1:0]}) << SH;
  assign xs[0] = rdr_pkg::GAIN_Q30;
  assign ys[0] = '0;
  assign rs[0] = rdr_pkg::ACC_W'({2'b00, ph[29:0]});
  assign qd[0] = ph[31:30];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    logic [1:0] qd_r;
    rdr_rot_cell #(.STAGE(i)) u_cell (
      .clk(clk), .en(en), .x_i(xs[i]), .y_i(ys[i]), .res_i(rs[i]),
      .x_o(xs[i+1]), .y_o(ys[i+1]), .res_o(rs[i+1]));
    always_ff @(posedge clk) begin
      if (en) qd_r <= qd[i];
    end
    assign qd[i+1] = qd_r;
  end

  // round Q2.30 to Q2.16 and unfold quadrant
  assign xr = (xs[CORDIC_STAGES] + rdr_pkg::DW'(8192)) >>> 14;
  assign yr = (ys[CORDIC_STAGES] + rdr_pkg::DW'(8192)) >>> 14;
  assign c = rdr_pkg::QW'(xr);
  assign s = rdr_pkg::QW'(yr);
  always_comb begin
    case (qd[CORDIC_STAGES])
      2'd0:    begin cos_o = c;  sin_o = s;  end
      2'd1:    begin cos_o = -s; sin_o = c;  end
      2'd2:    begin cos_o = -c; sin_o = -s; end
      default: begin cos_o = s;  sin_o = -c; end
    endcase
  end
endmodule

// File: sv/rdr_atan2.sv
// Four-quadrant arctangent with magnitude: pre-fold plus vectoring cells.
// Depends on rdr_pkg and rdr_vec_cell.
module rdr_atan2 #(
  parameter int CORDIC_STAGES = rdr_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  rdr_pkg::q16_t  x_i,
  input  rdr_pkg::q16_t  y_i,
  output rdr_pkg::acc_t  ang_o,
  output rdr_pkg::dat_t  xfin_o,
  output logic           zero_o
);
  rdr_pkg::dat_t xs [CORDIC_STAGES+1];
  rdr_pkg::dat_t ys [CORDIC_STAGES+1];
  rdr_pkg::acc_t as [CORDIC_STAGES+1];
  logic          zs [CORDIC_STAGES+1];
  logic          neg;

  // negate for left half plane, scale to Q2.30
  assign neg   = x_i[rdr_pkg::QW-1];
  assign xs[0] = (neg ? -rdr_pkg::DW'(x_i) : rdr_pkg::DW'(x_i)) <<< 14;
  assign ys[0] = (neg ? -rdr_pkg::DW'(y_i) : rdr_pkg::DW'(y_i)) <<< 14;
  assign as[0] = neg ? rdr_pkg::HALF_TURN : '0;
  assign zs[0] = (x_i == '0) && (y_i == '0);

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    logic z_r;
    rdr_vec_cell #(.STAGE(i)) u_cell (
      .clk(clk), .en(en), .x_i(xs[i]), .y_i(ys[i]), .acc_i(as[i]),
      .x_o(xs[i+1]), .y_o(ys[i+1]), .acc_o(as[i+1]));
    always_ff @(posedge clk) begin
      if (en) z_r <= zs[i];
    end
    assign zs[i+1] = z_r;
  end

  assign zero_o = zs[CORDIC_STAGES];
  assign ang_o  = zero_o ? '0 : as[CORDIC_STAGES];
  assign xfin_o = xs[CORDIC_STAGES];
endmodule

// File: sv/relative_direction_rotation_top.sv
// Relative direction rotation: builds the unit vector of the relative direction,
// turns it by the base zenith about Y and the base azimuth about Z, and returns
// zenith and azimuth. Fully pipelined: one word per cycle while the output is not
// stalled. There are 3*CORDIC_STAGES+6 register stages (three CORDIC chains in
// series: sin/cos, azimuth vectoring, zenith vectoring; three multiply stages,
// two magnitude stages and the output register).
// The pipeline advances whenever the output register is free or being taken.
// Depends on rdr_pkg, rdr_if, rdr_sincos, rdr_atan2.
module relative_direction_rotation_top #(
  parameter int ANGLE_BITS    = rdr_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rdr_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rdr_if.sink   in_ch,
  rdr_if.source out_ch
);
  localparam int LAT = 3*CORDIC_STAGES + 5;
  localparam int SH  = rdr_pkg::PH_W - ANGLE_BITS;

  logic en;
  logic [LAT-1:0] vld_r;
  logic           out_vld_r;
  rdr_pkg::out_word_t out_r;
  rdr_pkg::in_word_t  iw;

  assign iw = in_ch.data;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  rdr_pkg::q16_t cbz, sbz, cba, sba, crz, srz, cra, sra;
  rdr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc0 (
    .clk(clk), .en(en), .ang_i(iw.base_zenith),  .cos_o(cbz), .sin_o(sbz));
  rdr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc1 (
    .clk(clk), .en(en), .ang_i(iw.base_azimuth), .cos_o(cba), .sin_o(sba));
  rdr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc2 (
    .clk(clk), .en(en), .ang_i(iw.rel_zenith),   .cos_o(crz), .sin_o(srz));
  rdr_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc3 (
    .clk(clk), .en(en), .ang_i(iw.rel_azimuth),  .cos_o(cra), .sin_o(sra));

  // stage A: relative vector
  rdr_pkg::q16_t x_r, y_r, z_r, cbz_a, sbz_a, cba_a, sba_a;
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= rdr_pkg::mac2(srz, cra, '0, '0);
      y_r <= rdr_pkg::mac2(srz, sra, '0, '0);
      z_r <= crz;
      cbz_a <= cbz; sbz_a <= sbz; cba_a <= cba; sba_a <= sba;
    end
  end

  // stage B: rotate about Y
  rdr_pkg::q16_t x1_r, z1_r, y1_r, cba_b, sba_b;
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= rdr_pkg::mac2(x_r, cbz_a, z_r, sbz_a);
      z1_r <= rdr_pkg::mac2(-x_r, sbz_a, z_r, cbz_a);
      y1_r <= y_r; cba_b <= cba_a; sba_b <= sba_a;
    end
  end

  // stage C: rotate about Z
  rdr_pkg::q16_t x2_r, y2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= rdr_pkg::mac2(x1_r, cba_b, -y1_r, sba_b);
      y2_r <= rdr_pkg::mac2(x1_r, sba_b, y1_r, cba_b);
    end
  end

  // z1 delay line across stage C, the azimuth chain and magnitude stages
  localparam int ZD = CORDIC_STAGES + 3;
  rdr_pkg::q16_t zd_r [ZD];
  always_ff @(posedge clk) begin
    if (en) begin
      zd_r[0] <= z1_r;
      for (int i = 1; i < ZD; i++) zd_r[i] <= zd_r[i-1];
    end
  end

  rdr_pkg::acc_t az_ang;
  rdr_pkg::dat_t az_x;
  logic          az_zero;
  rdr_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_az (
    .clk(clk), .en(en), .x_i(x2_r), .y_i(y2_r),
    .ang_o(az_ang), .xfin_o(az_x), .zero_o(az_zero));

  // magnitude: gain multiply, then two roundings
  logic signed [71:0] mprod_r;
  logic               mzero_r;
  rdr_pkg::q16_t      rho_r;
  logic signed [71:0] t30;
  logic signed [71:0] t16;
  assign t30 = (mprod_r + 72'sd536870912) >>> 30;
  assign t16 = (t30 + 72'sd8192) >>> 14;
  rdr_pkg::acc_t azd_r [2];
  always_ff @(posedge clk) begin
    if (en) begin
      mprod_r <= 72'(az_x) * 72'(rdr_pkg::GAIN_Q30);
      mzero_r <= az_zero;
      rho_r   <= mzero_r ? '0 : rdr_pkg::QW'(t16);
      azd_r[0] <= az_ang;
      azd_r[1] <= azd_r[0];
    end
  end

  // azimuth delay across the zenith chain
  rdr_pkg::acc_t azq_r [CORDIC_STAGES];
  rdr_pkg::acc_t az_fin;
  always_ff @(posedge clk) begin
    if (en) begin
      azq_r[0] <= azd_r[1];
      for (int i = 1; i < CORDIC_STAGES; i++) azq_r[i] <= azq_r[i-1];
    end
  end
  assign az_fin = azq_r[CORDIC_STAGES-1];

  rdr_pkg::acc_t ze_ang;
  rdr_pkg::dat_t ze_x;
  logic          ze_zero;
  rdr_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_ze (
    .clk(clk), .en(en), .x_i(zd_r[ZD-1]), .y_i(rho_r),
    .ang_o(ze_ang), .xfin_o(ze_x), .zero_o(ze_zero));

  // clamp, round and pack
  rdr_pkg::acc_t ze_c;
  logic [rdr_pkg::PH_W:0] ze_rnd, az_rnd;
  logic [rdr_pkg::PH_W-1:0] az_ph;
  always_comb begin
    ze_c = ze_ang;
    if (ze_ang[rdr_pkg::ACC_W-1]) ze_c = '0;
    else if (ze_ang > rdr_pkg::HALF_TURN) ze_c = rdr_pkg::HALF_TURN;
    az_ph  = az_fin[rdr_pkg::PH_W-1:0];
    ze_rnd = (33'(ze_c[rdr_pkg::PH_W-1:0]) + (33'(SH > 0) << (SH > 0 ? SH-1 : 0))) >> SH;
    az_rnd = (33'(az_ph) + (33'(SH > 0) << (SH > 0 ? SH-1 : 0))) >> SH;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[LAT-1];
    end
  end
  logic [rdr_pkg::FIELD_W-1:0] msk;
  assign msk = (ANGLE_BITS >= rdr_pkg::FIELD_W) ? '1 :
               rdr_pkg::FIELD_W'((33'd1 << ANGLE_BITS) - 33'd1);
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.out_zenith  <= rdr_pkg::FIELD_W'(ze_rnd) & msk;
      out_r.out_azimuth <= rdr_pkg::FIELD_W'(az_rnd) & msk;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  logic unused;
  assign unused = ^{ze_x, ze_zero};
endmodule

// File: sv/rdr_checker.sv
// Port-level checker for the rotation block, bound to the top level.
// Depends on rdr_pkg.
module rdr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rdr_pkg::out_word_t out_data
);
  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");
  // input is open whenever output is free
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input blocked with empty output");
  // input stalls only with a pending result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready) else $error("spurious input stall");
  // zenith stays within half a turn
  a_zen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_zenith <= 16'd32768) else $error("zenith out of range");
  // no result right after a reset cycle
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind relative_direction_rotation_top rdr_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data));

// File: test/relative_direction_rotation_top_test.sv
// Testbench for relative_direction_rotation_top: random and directed direction pairs,
// each result checked against a bit-exact CORDIC predictor written here.
// Depends on rdr_pkg, rdr_if and the block's RTL.
module relative_direction_rotation_top_test;

  localparam int LATENCY   = 3 * rdr_pkg::CORDIC_STAGES_DEF + 5;
  localparam int N_RANDOM  = 1030;
  localparam int IDLE_LIM  = 20000;
  localparam longint HALF_PH = 64'sd2147483648;
  localparam longint GAIN    = 64'sd652032874;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rdr_if #(.T(rdr_pkg::in_word_t))  in_ch ();
  rdr_if #(.T(rdr_pkg::out_word_t)) out_ch ();

  relative_direction_rotation_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rdr_pkg::in_word_t  pending_words[$];
  rdr_pkg::out_word_t expected_dirs[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  bit stim_done = 0;
  bit hold_off = 0;
  bit calm = 0;

  // arctangent table in phase units, same angles as the block's table
  function automatic longint atan_step(int i);
    longint tbl[32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000};
    return tbl[i];
  endfunction

  function automatic longint clip_q16(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint prod_sum(longint a, longint b, longint c, longint d);
    return clip_q16((a * b + c * d + 32768) >>> 16);
  endfunction

  // rotation-mode CORDIC: cos and sin of a 16-bit angle, Q2.16
  function automatic void angle_trig(logic [15:0] ang, output longint cq,
                                     output longint sq);
    logic [31:0] ph;
    longint res, x, y, dx, dy, c, s;
    ph = {ang, 16'h0};
    res = longint'(ph[29:0]);
    x = GAIN;
    y = 0;
    for (int i = 0; i < rdr_pkg::CORDIC_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (res >= 0) begin
        x -= dx; y += dy; res -= atan_step(i);
      end else begin
        x += dx; y -= dy; res += atan_step(i);
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    case (ph[31:30])
      2'd0: begin cq = c;  sq = s;  end
      2'd1: begin cq = -s; sq = c;  end
      2'd2: begin cq = -c; sq = -s; end
      default: begin cq = s; sq = -c; end
    endcase
  endfunction

  // vectoring-mode CORDIC: four-quadrant angle in phase units plus magnitude
  function automatic longint heading(longint x, longint y, output longint mag);
    longint acc, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      x = -x; y = -y; acc = HALF_PH;
    end
    x *= 16384;
    y *= 16384;
    for (int i = 0; i < rdr_pkg::CORDIC_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += atan_step(i);
      end else begin
        x -= dx; y += dy; acc -= atan_step(i);
      end
    end
    mag = (((x * GAIN + 64'sd536870912) >>> 30) + 8192) >>> 14;
    return acc;
  endfunction

  function automatic logic [15:0] phase_to_angle(longint p);
    logic [63:0] u;
    u = 64'(p) + 64'd32768;
    return u[31:16];
  endfunction

  function automatic rdr_pkg::out_word_t rotated_direction(rdr_pkg::in_word_t w);
    longint cbz, sbz, cba, sba, crz, srz, cra, sra_l, rho, unused;
    longint x, y, z, x1, z1, x2, y2, az, ze;
    rdr_pkg::out_word_t r;
    angle_trig(w.base_zenith, cbz, sbz);
    angle_trig(w.base_azimuth, cba, sba);
    angle_trig(w.rel_zenith, crz, srz);
    angle_trig(w.rel_azimuth, cra, sra_l);
    x = prod_sum(srz, cra, 0, 0);
    y = prod_sum(srz, sra_l, 0, 0);
    z = clip_q16(crz);
    x1 = prod_sum(x, cbz, z, sbz);
    z1 = prod_sum(-x, sbz, z, cbz);
    x2 = prod_sum(x1, cba, -y, sba);
    y2 = prod_sum(x1, sba, y, cba);
    az = heading(x2, y2, rho);
    ze = heading(z1, rho, unused);
    if (ze < 0) ze = 0;
    if (ze > HALF_PH) ze = HALF_PH;
    r.out_zenith = phase_to_angle(ze);
    r.out_azimuth = phase_to_angle(az & 64'hFFFF_FFFF);
    return r;
  endfunction

  function automatic rdr_pkg::in_word_t make_word(logic [15:0] bz, logic [15:0] ba,
                                                  logic [15:0] rz, logic [15:0] ra);
    rdr_pkg::in_word_t w;
    w.base_zenith = bz; w.base_azimuth = ba;
    w.rel_zenith = rz; w.rel_azimuth = ra;
    return w;
  endfunction

  // stimulus: directed corners, then random words
  initial begin
    logic [15:0] rz;
    // extremes and poles
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_words.push_back(make_word(16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF));
    pending_words.push_back(make_word(16'h8000, 16'h0000, 16'h0000, 16'h0000));
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'h8000, 16'h0000));
    pending_words.push_back(make_word(16'h4000, 16'h4000, 16'h4000, 16'hC000));
    pending_words.push_back(make_word(16'h4000, 16'h8000, 16'h4000, 16'h0000));
    // negative x into the arctangent, each quadrant
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'h4000, 16'h8000));
    pending_words.push_back(make_word(16'h2000, 16'h6000, 16'h3000, 16'hA000));
    pending_words.push_back(make_word(16'h6000, 16'hE000, 16'h5000, 16'h2000));
    // zenith above pi, bits above the nominal range
    pending_words.push_back(make_word(16'hC000, 16'h1234, 16'hFFFF, 16'h5555));
    pending_words.push_back(make_word(16'hFFFF, 16'hAAAA, 16'h8001, 16'h0001));
    pending_words.push_back(make_word(16'h7FFF, 16'h0001, 16'h0001, 16'h7FFF));
    // cancellation toward the zero vector
    pending_words.push_back(make_word(16'h8000, 16'h0000, 16'h8000, 16'h0000));
    pending_words.push_back(make_word(16'h4000, 16'h0000, 16'h4000, 16'h8000));
    for (int i = 0; i < N_RANDOM; i++) begin
      // mostly nominal zenith, some out of range
      rz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      pending_words.push_back(make_word(
        ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
        16'($urandom), rz, 16'($urandom)));
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_dirs.push_back(rotated_direction(in_ch.data));
        sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_words.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    rdr_pkg::out_word_t exp_dir;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (expected_dirs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: zen %h azi %h",
                     out_ch.data.out_zenith, out_ch.data.out_azimuth);
        end else begin
          exp_dir = expected_dirs.pop_front();
          if (exp_dir.out_zenith !== out_ch.data.out_zenith ||
              exp_dir.out_azimuth !== out_ch.data.out_azimuth) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected zen %h azi %h, got zen %h azi %h",
                       checked, exp_dir.out_zenith, exp_dir.out_azimuth,
                       out_ch.data.out_zenith, out_ch.data.out_azimuth);
          end
        end
      end
      out_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 9);
    end
  end

  // long receiver hold-off, then a stretch with no idling on either side
  initial begin
    wait (sent >= 300);
    hold_off = 1'b1;
    repeat (3 * LATENCY) @(posedge clk);
    hold_off = 1'b0;
    wait (sent >= 500);
    calm = 1'b1;
    wait (sent >= 700);
    calm = 1'b0;
  end

  // watchdog on cycles without any accepted word
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIM) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // reset, end-of-run wait, verdict
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0 && sent > 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("covered %0d direction words incl. poles, reversed axes, out-of-range zenith",
             sent);
    $display("checked %0d results, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && expected_dirs.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
